// ===== hdl/wlst_pkg.sv =====
// Shared types and constants for the windowed latency statistics block.
`default_nettype none

package wlst_pkg;

    localparam int WINDOW       = 512;
    localparam int SAMPLE_BITS  = 16;
    localparam int IDX_W        = $clog2(WINDOW);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SUM_W        = SAMPLE_BITS + IDX_W;
    localparam int SQ_W         = 2 * SAMPLE_BITS + IDX_W;
    localparam int PROD_W       = 2 * SAMPLE_BITS;
    localparam int QUO_W        = SUM_W;
    localparam int NARROW_STEPS = SAMPLE_BITS;
    localparam int STEP_W       = $clog2(QUO_W + 1);
    localparam int OUT_W        = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_WAVG_START,
        ST_WAVG_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic              wide;
        logic [SQ_W-1:0]   dividend;
        logic [SUM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/windowed_latency_statistics_top.sv =====
// Top level: sample ring, running sums, peak tracking and divider sequencing.
`default_nettype none

// Each transaction on the slave side carries one 16-bit duration sample and yields
// exactly one result transaction on the master side. The block works on one sample at
// a time: after acceptance it loads the ring and running sum, updates the square sum,
// then runs the divisions the item needs on the shared radix-2 divider, one quotient
// bit per cycle: a 16-bit quotient, or the full 25-bit quotient that the window
// average needs after a wrap with a zero last slot. Then it writes the result register,
// waiting while that register is stalled, and only then takes the next sample.
// A finished result waits in the output register while the next sample is taken.
// The 512-entry sample ring needs no clearing pass after reset: entries not yet
// written since reset read as zero through a ring-full flag.
module windowed_latency_statistics_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata,   // [15:0] average, [31:16] weighted_average,
                                             // [47:32] max_ever, [63:48] max_recent
    output logic             m_axis_tuser    // [0] weighted_valid
);

    localparam int SB = wlst_pkg::SAMPLE_BITS;

    wlst_pkg::state_t state_reg;
    wlst_pkg::state_t state_next;

    logic [SB-1:0]                   sample_reg;
    logic [wlst_pkg::IDX_W-1:0]      idx_reg;
    logic                            full_reg;
    logic                            last_nz_reg;
    logic [wlst_pkg::SUM_W-1:0]      sum_reg;
    logic [wlst_pkg::SQ_W-1:0]       sq_reg;
    logic [wlst_pkg::PROD_W-1:0]     old_sq_reg;
    logic [wlst_pkg::PROD_W-1:0]     new_sq_reg;
    logic [SB-1:0]                   peak_all_reg;
    logic [SB-1:0]                   peak_cur_reg;
    logic [SB-1:0]                   peak_prev_reg;
    logic [wlst_pkg::OUT_W-1:0]      held_avg_reg;
    logic [wlst_pkg::OUT_W-1:0]      wavg_reg;
    logic                            avg_div_reg;
    logic [wlst_pkg::CNT_W-1:0]      avg_dvs_reg;

    logic                            ram_we;
    logic                            ram_re;
    logic [SB-1:0]                   ram_rdata;
    logic [SB-1:0]                   old_sample;
    logic                            wrap;
    logic [SB-1:0]                   peak_cur_new;
    logic [SB-1:0]                   recent;
    logic                            out_free;

    wlst_pkg::div_req_t              div_req;
    wlst_pkg::div_rsp_t              div_rsp;

    wlst_ram #(
        .WIDTH (SB),
        .DEPTH (wlst_pkg::WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    wlst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Slots never written since reset read as zero.
    assign old_sample   = full_reg ? ram_rdata : '0;
    assign wrap         = idx_reg == wlst_pkg::IDX_W'(wlst_pkg::WINDOW - 1);
    assign peak_cur_new = (sample_reg > peak_cur_reg) ? sample_reg : peak_cur_reg;
    assign recent       = (peak_cur_reg > peak_prev_reg) ? peak_cur_reg : peak_prev_reg;
    assign out_free     = !m_axis_tvalid || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wlst_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = wlst_pkg::ST_LOAD;
                end
            end
            wlst_pkg::ST_LOAD:
            begin
                state_next = wlst_pkg::ST_SQ;
            end
            wlst_pkg::ST_SQ:
            begin
                if (last_nz_reg || idx_reg != '0)
                begin
                    state_next = wlst_pkg::ST_AVG_START;
                end
                else if (sum_reg != '0)
                begin
                    state_next = wlst_pkg::ST_WAVG_START;
                end
                else
                begin
                    state_next = wlst_pkg::ST_OUT;
                end
            end
            wlst_pkg::ST_AVG_START:
            begin
                state_next = wlst_pkg::ST_AVG_WAIT;
            end
            wlst_pkg::ST_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (sum_reg != '0) ? wlst_pkg::ST_WAVG_START : wlst_pkg::ST_OUT;
                end
            end
            wlst_pkg::ST_WAVG_START:
            begin
                state_next = wlst_pkg::ST_WAVG_WAIT;
            end
            wlst_pkg::ST_WAVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = wlst_pkg::ST_OUT;
                end
            end
            wlst_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = wlst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wlst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready    = 1'b0;
        ram_re           = 1'b0;
        ram_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.wide     = 1'b0;
        div_req.dividend = wlst_pkg::SQ_W'(sum_reg);
        div_req.divisor  = wlst_pkg::SUM_W'(avg_dvs_reg);
        case (state_reg)
            wlst_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_re        = s_axis_tvalid;
            end
            wlst_pkg::ST_LOAD:
            begin
                ram_we = 1'b1;
            end
            wlst_pkg::ST_AVG_START:
            begin
                // Whole-ring sum over a partial count: the quotient can exceed 16 bits.
                div_req.start = 1'b1;
                div_req.wide  = full_reg && !last_nz_reg;
            end
            wlst_pkg::ST_WAVG_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sq_reg;
                div_req.divisor  = sum_reg;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wlst_pkg::ST_IDLE;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            last_nz_reg   <= 1'b0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            peak_all_reg  <= '0;
            peak_cur_reg  <= '0;
            peak_prev_reg <= '0;
            held_avg_reg  <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == wlst_pkg::ST_OUT && out_free)
            begin
                m_axis_tvalid <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end
            case (state_reg)
                wlst_pkg::ST_LOAD:
                begin
                    sum_reg <= sum_reg - wlst_pkg::SUM_W'(old_sample)
                               + wlst_pkg::SUM_W'(sample_reg);
                    if (sample_reg > peak_all_reg)
                    begin
                        peak_all_reg <= sample_reg;
                    end
                    if (wrap)
                    begin
                        // Pass complete: retire the current peak.
                        idx_reg       <= '0;
                        full_reg      <= 1'b1;
                        last_nz_reg   <= sample_reg != '0;
                        peak_prev_reg <= peak_cur_new;
                        peak_cur_reg  <= '0;
                    end
                    else
                    begin
                        idx_reg      <= idx_reg + wlst_pkg::IDX_W'(1);
                        peak_cur_reg <= peak_cur_new;
                    end
                end
                wlst_pkg::ST_SQ:
                begin
                    sq_reg <= sq_reg - wlst_pkg::SQ_W'(old_sq_reg)
                              + wlst_pkg::SQ_W'(new_sq_reg);
                end
                wlst_pkg::ST_AVG_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        held_avg_reg <= wlst_pkg::OUT_W'(div_rsp.quotient);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            wlst_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    sample_reg <= s_axis_tdata[SB-1:0];
                end
            end
            wlst_pkg::ST_LOAD:
            begin
                old_sq_reg <= old_sample * old_sample;
                new_sq_reg <= sample_reg * sample_reg;
            end
            wlst_pkg::ST_SQ:
            begin
                wavg_reg    <= '0;
                avg_div_reg <= last_nz_reg || idx_reg != '0;
                avg_dvs_reg <= last_nz_reg ? wlst_pkg::CNT_W'(wlst_pkg::WINDOW)
                                           : wlst_pkg::CNT_W'(idx_reg);
            end
            wlst_pkg::ST_WAVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    wavg_reg <= wlst_pkg::OUT_W'(div_rsp.quotient);
                end
            end
            wlst_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    m_axis_tdata <= {wlst_pkg::OUT_W'(recent),
                                     wlst_pkg::OUT_W'(peak_all_reg),
                                     wavg_reg,
                                     held_avg_reg};
                    m_axis_tuser <= sum_reg != '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == wlst_pkg::ST_LOAD)
        else $error("accepted sample not loaded");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == wlst_pkg::ST_AVG_WAIT ||
                          state_reg == wlst_pkg::ST_WAVG_WAIT))
        else $error("divider result outside a wait state");
    a_avg_div_matches: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == wlst_pkg::ST_AVG_START |-> avg_div_reg && avg_dvs_reg != '0)
        else $error("average division started with a zero divisor");
    a_zero_sum_weighted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wlst_pkg::ST_OUT && sum_reg == '0) |-> wavg_reg == '0)
        else $error("weighted average nonzero on an empty window");
    a_prev_peak_before_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg |-> peak_prev_reg == '0)
        else $error("previous pass peak set before the first wrap");

endmodule

`default_nettype wire

// ===== hdl/wlst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wlst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wlst_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 16 or 25 steps per division.
`default_nettype none

module wlst_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wlst_pkg::div_req_t req,
    output wlst_pkg::div_rsp_t     rsp
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [wlst_pkg::STEP_W-1:0]        step_reg;
    logic [wlst_pkg::SUM_W-1:0]         rem_reg;
    logic [wlst_pkg::QUO_W-1:0]         low_reg;
    logic [wlst_pkg::QUO_W-1:0]         quo_reg;
    logic [wlst_pkg::SUM_W-1:0]         dvs_reg;

    logic [wlst_pkg::SUM_W:0]           trial;
    logic                               fits;
    logic [wlst_pkg::SUM_W:0]           diff;

    // The dividend bits above the steps run are below the divisor: a narrow run covers
    // a quotient known to fit 16 bits, a wide run produces the full 25-bit quotient.
    assign trial = {rem_reg, low_reg[wlst_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == wlst_pkg::STEP_W'(1));
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= req.wide ? wlst_pkg::STEP_W'(wlst_pkg::QUO_W)
                                     : wlst_pkg::STEP_W'(wlst_pkg::NARROW_STEPS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - wlst_pkg::STEP_W'(1);
                if (step_reg == wlst_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            if (req.wide)
            begin
                rem_reg <= wlst_pkg::SUM_W'(req.dividend >> wlst_pkg::QUO_W);
                low_reg <= req.dividend[wlst_pkg::QUO_W-1:0];
            end
            else
            begin
                rem_reg <= wlst_pkg::SUM_W'(req.dividend >> wlst_pkg::NARROW_STEPS);
                low_reg <= {req.dividend[wlst_pkg::NARROW_STEPS-1:0],
                            {(wlst_pkg::QUO_W - wlst_pkg::NARROW_STEPS){1'b0}}};
            end
            dvs_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[wlst_pkg::SUM_W-1:0] : trial[wlst_pkg::SUM_W-1:0];
            low_reg <= {low_reg[wlst_pkg::QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[wlst_pkg::QUO_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a preceding run");
    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");
    a_step_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> step_reg == '0)
        else $error("divider step count left over");

endmodule

`default_nettype wire
